// ===== rtl/ste_pkg.sv =====
// Package for the sorted table engine: payload structs, command and status codes,
// controller states, datapath operations and the control/status structs between them.
// No dependencies.
package ste_pkg;

   // Table size, the widths that follow from it and the data width.
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;

   // Command codes.
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_SEARCH = 2'd2;

   // Status codes.
   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_FULL   = 2'd1;
   localparam logic [1:0] STS_ABSENT = 2'd2;

   // Request payload.
   typedef struct packed {
      logic [1:0]               command;
      logic signed [DATA_W-1:0] value;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [1:0]               status;
      logic [POS_W-1:0]         position;
      logic [POS_W-1:0]         entry_count;
      logic signed [DATA_W-1:0] min_value;
      logic signed [DATA_W-1:0] max_value;
   } rsp_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS,
      S_INS_LAST,
      S_FIND,
      S_DEL,
      S_MIN,
      S_MAX,
      S_CAP,
      S_DONE
   } state_type;

   // Datapath operations, one per cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SET_FULL,
      OP_SET_ABSENT,
      OP_INS_HEAD,
      OP_INS_INIT,
      OP_INS_STEP,
      OP_FIND_INIT,
      OP_FIND_STEP,
      OP_DEL_STEP,
      OP_FETCH_MIN,
      OP_FETCH_MAX,
      OP_CAP_MAX,
      OP_EMIT
   } op_type;

   // Controller to datapath.
   typedef struct packed {
      op_type op;
   } dp_ctrl_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] command;
      logic       full;
      logic       empty;
      logic       gt;
      logic       eq;
      logic       at_zero;
      logic       at_last;
      logic       out_free;
   } dp_status_type;

endpackage

// ===== rtl/ste_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module ste_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ste_ctrl.sv =====
// Controller state machine of the sorted table engine.
// Depends on ste_pkg; drives the datapath through ste_pkg::dp_ctrl_type.
module ste_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ste_pkg::dp_status_type sts,
   output ste_pkg::dp_ctrl_type   ctrl
);

   ste_pkg::state_type state_ff;
   ste_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ste_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and per-cycle datapath operation.
   always_comb begin
      state_in  = state_ff;
      ctrl.op   = ste_pkg::OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ste_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.op  = ste_pkg::OP_LOAD;
               state_in = ste_pkg::S_DISPATCH;
            end
         end
         ste_pkg::S_DISPATCH: begin
            state_in = ste_pkg::S_MIN;
            if (sts.command == ste_pkg::CMD_INSERT) begin
               if (sts.full) begin
                  ctrl.op = ste_pkg::OP_SET_FULL;
               end else if (sts.empty) begin
                  ctrl.op = ste_pkg::OP_INS_HEAD;
               end else begin
                  ctrl.op  = ste_pkg::OP_INS_INIT;
                  state_in = ste_pkg::S_INS;
               end
            end else if (sts.command == ste_pkg::CMD_DELETE ||
                         sts.command == ste_pkg::CMD_SEARCH) begin
               if (sts.empty) begin
                  ctrl.op = ste_pkg::OP_SET_ABSENT;
               end else begin
                  ctrl.op  = ste_pkg::OP_FIND_INIT;
                  state_in = ste_pkg::S_FIND;
               end
            end
         end
         ste_pkg::S_INS: begin
            // Walk down, moving larger entries up one place.
            ctrl.op = ste_pkg::OP_INS_STEP;
            if (!sts.gt) begin
               state_in = ste_pkg::S_MIN;
            end else if (sts.at_zero) begin
               state_in = ste_pkg::S_INS_LAST;
            end
         end
         ste_pkg::S_INS_LAST: begin
            ctrl.op  = ste_pkg::OP_INS_HEAD;
            state_in = ste_pkg::S_MIN;
         end
         ste_pkg::S_FIND: begin
            // Walk up until a match, an entry past the value or the last entry.
            ctrl.op = ste_pkg::OP_FIND_STEP;
            if (sts.eq) begin
               if (sts.command == ste_pkg::CMD_DELETE && !sts.at_last) begin
                  state_in = ste_pkg::S_DEL;
               end else begin
                  state_in = ste_pkg::S_MIN;
               end
            end else if (sts.gt || sts.at_last) begin
               state_in = ste_pkg::S_MIN;
            end
         end
         ste_pkg::S_DEL: begin
            ctrl.op = ste_pkg::OP_DEL_STEP;
            if (sts.at_last) begin
               state_in = ste_pkg::S_MIN;
            end
         end
         ste_pkg::S_MIN: begin
            ctrl.op  = ste_pkg::OP_FETCH_MIN;
            state_in = ste_pkg::S_MAX;
         end
         ste_pkg::S_MAX: begin
            ctrl.op  = ste_pkg::OP_FETCH_MAX;
            state_in = ste_pkg::S_CAP;
         end
         ste_pkg::S_CAP: begin
            ctrl.op  = ste_pkg::OP_CAP_MAX;
            state_in = ste_pkg::S_DONE;
         end
         ste_pkg::S_DONE: begin
            if (sts.out_free) begin
               ctrl.op  = ste_pkg::OP_EMIT;
               state_in = ste_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ste_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/ste_datapath.sv =====
// Datapath of the sorted table engine: entry memory, walk pointer, fill count,
// result registers and the response output register.
// Depends on ste_pkg and ste_ram.
module ste_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ste_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ste_pkg::rsp_type       rsp_data,
   input  ste_pkg::dp_ctrl_type   ctrl,
   output ste_pkg::dp_status_type sts
);

   logic [1:0]                        cmd_ff;
   logic signed [ste_pkg::DATA_W-1:0] value_ff;
   logic [ste_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [ste_pkg::IDX_W-1:0]         dptr_ff, dptr_in;
   logic [1:0]                        status_ff, status_in;
   logic [ste_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic [ste_pkg::DATA_W-1:0]        min_ff, min_in;
   logic [ste_pkg::DATA_W-1:0]        max_ff, max_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   ste_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic                              wr_en, rd_en;
   logic [ste_pkg::IDX_W-1:0]         wr_addr, rd_addr;
   logic [ste_pkg::DATA_W-1:0]        wr_data, rd_data;
   logic [ste_pkg::IDX_W-1:0]         last_idx;
   logic                              gt, eq, at_zero, at_last;

   // Entry store.
   ste_ram #(
      .WIDTH (ste_pkg::DATA_W),
      .DEPTH (ste_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Compare of the entry on the read port against the command value.
   assign last_idx = ste_pkg::IDX_W'(count_ff - ste_pkg::CNT_W'(1));
   assign gt       = $signed(rd_data) > value_ff;
   assign eq       = $signed(rd_data) == value_ff;
   assign at_zero  = dptr_ff == '0;
   assign at_last  = dptr_ff == last_idx;

   assign sts.command  = cmd_ff;
   assign sts.full     = count_ff == ste_pkg::CNT_W'(ste_pkg::CAPACITY);
   assign sts.empty    = count_ff == '0;
   assign sts.gt       = gt;
   assign sts.eq       = eq;
   assign sts.at_zero  = at_zero;
   assign sts.at_last  = at_last;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // Memory port control for each operation.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = dptr_ff + ste_pkg::IDX_W'(1);
      wr_data = value_ff;
      rd_en   = 1'b0;
      rd_addr = dptr_ff + ste_pkg::IDX_W'(1);
      case (ctrl.op)
         ste_pkg::OP_INS_HEAD: begin
            wr_en   = 1'b1;
            wr_addr = '0;
         end
         ste_pkg::OP_INS_INIT: begin
            rd_en   = 1'b1;
            rd_addr = last_idx;
         end
         ste_pkg::OP_INS_STEP: begin
            wr_en   = 1'b1;
            wr_data = gt ? rd_data : value_ff;
            rd_en   = gt && !at_zero;
            rd_addr = dptr_ff - ste_pkg::IDX_W'(1);
         end
         ste_pkg::OP_FIND_INIT: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         ste_pkg::OP_FIND_STEP: begin
            rd_en = eq ? (cmd_ff == ste_pkg::CMD_DELETE && !at_last) : (!gt && !at_last);
         end
         ste_pkg::OP_DEL_STEP: begin
            wr_en   = 1'b1;
            wr_addr = dptr_ff - ste_pkg::IDX_W'(1);
            wr_data = rd_data;
            rd_en   = !at_last;
         end
         ste_pkg::OP_FETCH_MIN: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         ste_pkg::OP_FETCH_MAX: begin
            rd_en   = 1'b1;
            rd_addr = last_idx;
         end
         default: begin
         end
      endcase
   end

   // Next values of the datapath registers.
   always_comb begin
      dptr_in      = dptr_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (ctrl.op)
         ste_pkg::OP_LOAD: begin
            status_in = ste_pkg::STS_OK;
            pos_in    = '0;
         end
         ste_pkg::OP_SET_FULL: begin
            status_in = ste_pkg::STS_FULL;
         end
         ste_pkg::OP_SET_ABSENT: begin
            status_in = ste_pkg::STS_ABSENT;
         end
         ste_pkg::OP_INS_HEAD: begin
            count_in = count_ff + ste_pkg::CNT_W'(1);
         end
         ste_pkg::OP_INS_INIT: begin
            dptr_in = last_idx;
         end
         ste_pkg::OP_INS_STEP: begin
            if (!gt) begin
               count_in = count_ff + ste_pkg::CNT_W'(1);
            end else if (!at_zero) begin
               dptr_in = dptr_ff - ste_pkg::IDX_W'(1);
            end
         end
         ste_pkg::OP_FIND_INIT: begin
            dptr_in = '0;
         end
         ste_pkg::OP_FIND_STEP: begin
            if (eq) begin
               if (cmd_ff == ste_pkg::CMD_SEARCH) begin
                  pos_in = ste_pkg::POS_W'(ste_pkg::CNT_W'(dptr_ff) + ste_pkg::CNT_W'(1));
               end else if (at_last) begin
                  count_in = count_ff - ste_pkg::CNT_W'(1);
               end
            end else if (gt || at_last) begin
               status_in = ste_pkg::STS_ABSENT;
            end
            if (rd_en) begin
               dptr_in = dptr_ff + ste_pkg::IDX_W'(1);
            end
         end
         ste_pkg::OP_DEL_STEP: begin
            if (at_last) begin
               count_in = count_ff - ste_pkg::CNT_W'(1);
            end else begin
               dptr_in = dptr_ff + ste_pkg::IDX_W'(1);
            end
         end
         ste_pkg::OP_FETCH_MAX: begin
            min_in = rd_data;
         end
         ste_pkg::OP_CAP_MAX: begin
            max_in = rd_data;
         end
         ste_pkg::OP_EMIT: begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.status      = status_ff;
            rsp_data_in.position    = pos_ff;
            rsp_data_in.entry_count = ste_pkg::POS_W'(count_ff);
            rsp_data_in.min_value   = (count_ff == '0) ? '0 : $signed(min_ff);
            rsp_data_in.max_value   = (count_ff == '0) ? '0 : $signed(max_ff);
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers; the request is captured on its transfer.
   always_ff @(posedge clock) begin
      if (ctrl.op == ste_pkg::OP_LOAD) begin
         cmd_ff   <= req_data.command;
         value_ff <= req_data.value;
      end
      dptr_ff     <= dptr_in;
      status_ff   <= status_in;
      pos_ff      <= pos_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/sorted_table_engine.sv =====
// Sorted table engine. Keeps up to 64 signed 32-bit values in ascending order in a
// one-write, one-read memory. Insert walks down from the top entry, moving each larger
// entry up one place, then writes the value; delete walks up to the first match and moves
// the following entries down; search walks up to the first entry not below the value.
// Every command returns one response with status, position, count, minimum and maximum.
// Each insert or delete step moves one entry per cycle through the single memory port pair.
// The response sits in an output register, so a new request is taken while it waits.
// The entry memory needs no clearing after reset: only entries below the fill count
// are used, and an empty table reports zero extremes.
// Depends on ste_pkg, ste_ctrl and ste_datapath.
module sorted_table_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ste_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ste_pkg::rsp_type rsp_data
);

   ste_pkg::dp_ctrl_type   ctrl;
   ste_pkg::dp_status_type sts;

   // Sequencer.
   ste_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctrl      (ctrl)
   );

   // Storage and compare logic.
   ste_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .ctrl      (ctrl),
      .sts       (sts)
   );

endmodule

// ===== rtl/ste_checker.sv =====
// Port-level checks for the sorted table engine, attached by bind.
// Depends on ste_pkg and sorted_table_engine.
module ste_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ste_pkg::rsp_type rsp_data
);

   // A request transfer starts a command, so the next cycle takes no request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a command is in progress");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Only a found search reports a position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.position != '0 |-> rsp_data.status == ste_pkg::STS_OK)
      else $error("position reported without a hit");

   // A full status only comes with a full table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ste_pkg::STS_FULL |->
      rsp_data.entry_count == ste_pkg::POS_W'(ste_pkg::CAPACITY))
      else $error("full status with a table that is not full");

   // An empty table reports zero extremes; otherwise the minimum does not exceed the maximum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count == '0 && rsp_data.min_value == '0 &&
                     rsp_data.max_value == '0) ||
                    (rsp_data.entry_count != '0 && rsp_data.min_value <= rsp_data.max_value))
      else $error("minimum and maximum inconsistent");

endmodule

bind sorted_table_engine ste_checker u_checker (.*);
